// ----- rtl/core/sws_pkg.sv -----
// Package for the sliding-window sender with fast retransmit.
// Holds the item and action codes, the result types and the sizing constants.
// No dependencies; every module of the block imports it.
package sws_pkg;

  // Sequence space and ring sizing (powers of two, so sequence arithmetic wraps).
  localparam int SeqSpace       = 8;
  localparam int SeqW           = $clog2(SeqSpace);
  localparam int WindowSlots    = 8;
  localparam int SlotW          = $clog2(WindowSlots);
  localparam int Capacity       = (WindowSlots < SeqSpace) ? WindowSlots : (SeqSpace - 1);
  localparam int HeldW          = 4;
  localparam int PayloadW       = 64;
  localparam int PayloadBitsDef = 64;
  localparam int MaxResults     = 3;
  localparam int CountW         = 2;
  localparam int WinSizeW       = 3;
  localparam logic [WinSizeW-1:0] WindowSizeRst = WinSizeW'(4);
  localparam logic [HeldW-1:0]    CapacityVal   = HeldW'(Capacity);
  localparam int DupRetx        = 3;

  // Kind of input item.
  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_TIMER = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e_t;

  // Action reported by one result.
  typedef enum logic [2:0] {
    ACT_TX     = 3'd0,
    ACT_RETX   = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_REFUSE = 3'd4
  } action_t;

  // One result transaction.
  typedef struct packed {
    action_t             action;
    logic [SeqW-1:0]     seq;
    logic [PayloadW-1:0] payload;
    logic                full;
    logic [HeldW-1:0]    held;
    logic                last;
  } result_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [CountW-1:0]             count;
    result_t [MaxResults-1:0]      res;
  } bundle_t;

endpackage

// ----- rtl/core/sws_slot_ring.sv -----
// Generic RAM with one write port and one registered read port.
// Holds the payloads of the held packets, one slot per sequence number modulo the depth.
// Depends on sws_pkg for its default sizes.
module sws_slot_ring
  import sws_pkg::*;
#(
  parameter int WIDTH = PayloadW,
  parameter int DEPTH = WindowSlots
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_slot,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_slot,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // A slot is only read while it holds an unacknowledged packet, so no reset is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_slot] <= wr_data;
    end
  end

  // Registered read; a write to the slot being read passes straight through.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == rd_slot)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= slot_r[rd_slot];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/sws_engine.sv -----
// Input register, protocol state and per-item decision logic of the sender.
// Produces the whole group of results for one item in a single pass.
// Depends on sws_pkg; drives the payload ring sws_slot_ring.
module sws_engine
  import sws_pkg::*;
#(
  parameter int PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [PayloadW-1:0]     in_payload_word,
  input  logic [SeqW-1:0]         in_ack_number,
  input  logic                    in_checksum_ok,
  input  logic [WinSizeW-1:0]     window_size,
  input  logic                    can_load,
  output logic                    load,
  output bundle_t                 bundle,
  output logic                    wr_en,
  output logic [SlotW-1:0]        wr_slot,
  output logic [PAYLOAD_BITS-1:0] wr_data,
  output logic [SlotW-1:0]        rd_slot,
  input  logic [PAYLOAD_BITS-1:0] rd_data
);

  // Registered input transaction.
  logic                    q_valid_r;
  logic [1:0]              q_func_r;
  logic [PAYLOAD_BITS-1:0] q_payload_r;
  logic [SeqW-1:0]         q_ack_r;
  logic                    q_ok_r;

  // Protocol state.
  logic [SeqW-1:0]   base_r, base_nxt;
  logic [SeqW-1:0]   next_r, next_nxt;
  logic              full_r, full_nxt;
  logic [HeldW-1:0]  held_r, held_nxt;
  logic [1:0]        dup_r, dup_nxt;
  logic [SeqW-1:0]   prev_ack_r, prev_ack_nxt;
  logic              prev_vld_r, prev_vld_nxt;

  logic fire;

  assign fire     = q_valid_r && can_load;
  assign in_ready = !q_valid_r || fire;
  assign load     = fire;

  // The ring read is registered, so it is addressed with the window base of the next cycle.
  assign rd_slot  = fire ? base_nxt[SlotW-1:0] : base_r[SlotW-1:0];

  // Input register: refills whenever the held item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ready) begin
      q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_func_r    <= in_func;
      q_payload_r <= in_payload_word[PAYLOAD_BITS-1:0];
      q_ack_r     <= in_ack_number;
      q_ok_r      <= in_checksum_ok;
    end
  end

  // Decision logic for the item in the input register.
  always_comb begin
    logic [SeqW-1:0]  next_inc;
    logic [1:0]       dup_tmp;
    logic [HeldW-1:0] moved;
    logic [HeldW-1:0] held_left;
    logic             resend;

    base_nxt     = base_r;
    next_nxt     = next_r;
    full_nxt     = full_r;
    held_nxt     = held_r;
    dup_nxt      = dup_r;
    prev_ack_nxt = prev_ack_r;
    prev_vld_nxt = prev_vld_r;
    bundle       = '0;
    wr_en        = 1'b0;
    wr_slot      = next_r[SlotW-1:0];
    wr_data      = q_payload_r;
    next_inc     = next_r + SeqW'(1);
    dup_tmp      = '0;
    moved        = '0;
    held_left    = '0;
    resend       = 1'b0;

    unique case (func_e_t'(q_func_r))
      FUNC_SEND: begin
        if (full_r || (held_r >= CapacityVal)) begin
          bundle.count         = CountW'(1);
          bundle.res[0].action = ACT_REFUSE;
          bundle.res[0].seq    = next_r;
        end else begin
          wr_en                 = fire;
          bundle.res[0].action  = ACT_TX;
          bundle.res[0].seq     = next_r;
          bundle.res[0].payload = PayloadW'(q_payload_r);
          bundle.count          = CountW'(1);
          if (base_r == next_r) begin
            bundle.res[1].action = ACT_START;
            bundle.res[1].seq    = next_r;
            bundle.count         = CountW'(2);
          end
          next_nxt = next_inc;
          held_nxt = held_r + HeldW'(1);
          if ((SeqW'(next_inc - base_r) == SeqW'(window_size)) ||
              (held_nxt >= CapacityVal)) begin
            full_nxt = 1'b1;
          end
        end
      end
      FUNC_ACK: begin
        // Duplicate tracking runs whatever the checksum says.
        if (prev_vld_r && (q_ack_r == prev_ack_r)) begin
          dup_tmp = dup_r + 2'd1;
        end else begin
          prev_ack_nxt = q_ack_r;
          prev_vld_nxt = 1'b1;
          dup_tmp      = 2'd0;
        end
        if (dup_tmp == 2'(DupRetx)) begin
          dup_nxt = 2'd0;
          resend  = 1'b1;
        end else begin
          dup_nxt = dup_tmp;
          moved   = HeldW'(SeqW'(q_ack_r - base_r)) + HeldW'(1);
          if ((held_r != '0) && q_ok_r && (moved <= held_r)) begin
            held_left            = held_r - moved;
            base_nxt             = q_ack_r + SeqW'(1);
            full_nxt             = 1'b0;
            held_nxt             = held_left;
            bundle.res[0].action = ACT_STOP;
            bundle.res[0].seq    = base_r;
            bundle.count         = CountW'(1);
            if (held_left != '0) begin
              bundle.res[1].action = ACT_START;
              bundle.res[1].seq    = base_nxt;
              bundle.count         = CountW'(2);
            end
          end
        end
      end
      FUNC_TIMER: begin
        resend = 1'b1;
      end
      FUNC_NONE: begin
        bundle.count = '0;
      end
      default: begin
        bundle.count = '0;
      end
    endcase

    // Timeout and fast retransmit: restart the timer and resend the oldest packet.
    if (resend && (held_r != '0)) begin
      bundle.res[0].action  = ACT_STOP;
      bundle.res[0].seq     = base_r;
      bundle.res[1].action  = ACT_START;
      bundle.res[1].seq     = base_r;
      bundle.res[2].action  = ACT_RETX;
      bundle.res[2].seq     = base_r;
      bundle.res[2].payload = PayloadW'(rd_data);
      bundle.count          = CountW'(3);
    end

    // Every result carries the state after the item; the final one is flagged.
    for (int k = 0; k < MaxResults; k++) begin
      bundle.res[k].full = full_nxt;
      bundle.res[k].held = held_nxt;
      bundle.res[k].last = (bundle.count == CountW'(k + 1));
    end
  end

  // State update on each processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      next_r     <= '0;
      full_r     <= 1'b0;
      held_r     <= '0;
      dup_r      <= '0;
      prev_ack_r <= '0;
      prev_vld_r <= 1'b0;
    end else if (fire) begin
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      full_r     <= full_nxt;
      held_r     <= held_nxt;
      dup_r      <= dup_nxt;
      prev_ack_r <= prev_ack_nxt;
      prev_vld_r <= prev_vld_nxt;
    end
  end

  // The held count never exceeds the ring capacity.
  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CapacityVal)
    else $error("held count above capacity");

  // Below capacity, the next sequence number sits exactly held_count past the window base.
  a_held_span: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == CapacityVal) || (HeldW'(SeqW'(next_r - base_r)) == held_r))
    else $error("window base and next sequence disagree with held count");

  // State only moves when an item is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(held_r) && $stable(base_r) && $stable(next_r))
    else $error("state changed without a processed item");

endmodule

// ----- rtl/core/sws_result_buf.sv -----
// Result register: hands one item's results out one a cycle while out_ready is high.
// Takes a new group in the cycle its last result is taken, so items flow back to back.
// Depends on sws_pkg.
module sws_result_buf
  import sws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bundle_t           bundle,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_res
);

  logic                         have_r, have_nxt;
  logic [CountW-1:0]            cnt_r, cnt_nxt;
  logic [CountW-1:0]            idx_r, idx_nxt;
  result_t [MaxResults-1:0]     res_r;

  logic pop;
  logic last_pop;

  assign out_valid = have_r;
  assign out_res   = res_r[idx_r];
  assign pop       = have_r && out_ready;
  assign last_pop  = pop && (idx_r == (cnt_r - CountW'(1)));
  assign can_load  = !have_r || last_pop;

  // Next position in the result group.
  always_comb begin
    have_nxt = have_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    priority if (load) begin
      have_nxt = (bundle.count != '0);
      cnt_nxt  = bundle.count;
      idx_nxt  = '0;
    end else if (last_pop) begin
      have_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      have_r <= have_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end
  end

  // A held group is never empty and the index stays inside it.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("result index outside the held group");

  // Taking a result that is not the last one steps to the next.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !last_pop |=> have_r && (idx_r == $past(idx_r) + CountW'(1)))
    else $error("result index did not advance");

  // Only the final result of a group is flagged last.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (out_res.last == (idx_r == (cnt_r - CountW'(1)))))
    else $error("last flag out of place");

endmodule

// ----- rtl/core/sliding_window_sender_fast_retx_core.sv -----
// Top level of the sliding-window sender with cumulative ACKs and fast retransmit.
// Depends on sws_pkg, sws_slot_ring, sws_engine and sws_result_buf.
//
//   Channel | Handshake             | Contents
//   in_     | in_valid / in_ready   | func, payload_word, ack_number, checksum_ok
//   out_    | out_valid / out_ready | action, seq_number, packet_payload, window_full,
//           |                       | packets_held, last
//   cfg_    | cfg_valid / cfg_ready | window_size (always ready)
//
// An item is taken into the input register and decided there once the result register
// can load. Its results, one to three or none, are then registered and handed out one
// per cycle while out_ready is high. The result register sets this pace.
// Reset (rst_n low, synchronous) empties the window and sets window_size to 4.
// While the final result waits on out_ready, one more item is taken and held.
module sliding_window_sender_fast_retx_core
  import sws_pkg::*;
#(
  parameter int PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [PayloadW-1:0] in_payload_word,
  input  logic [SeqW-1:0]     in_ack_number,
  input  logic                in_checksum_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_action,
  output logic [SeqW-1:0]     out_seq_number,
  output logic [PayloadW-1:0] out_packet_payload,
  output logic                out_window_full,
  output logic [HeldW-1:0]    out_packets_held,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WinSizeW-1:0] cfg_window_size
);

  logic [WinSizeW-1:0]     window_size_r;
  logic                    can_load;
  logic                    load;
  bundle_t                 bundle;
  logic                    wr_en;
  logic [SlotW-1:0]        wr_slot;
  logic [PAYLOAD_BITS-1:0] wr_data;
  logic [SlotW-1:0]        rd_slot;
  logic [PAYLOAD_BITS-1:0] rd_data;
  result_t                 out_res;

  // Window size register; writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WindowSizeRst;
    end else if (cfg_valid && cfg_ready) begin
      window_size_r <= cfg_window_size;
    end
  end

  sws_slot_ring #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WindowSlots)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_slot (wr_slot),
    .wr_data (wr_data),
    .rd_slot (rd_slot),
    .rd_data (rd_data)
  );

  sws_engine #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_payload_word (in_payload_word),
    .in_ack_number   (in_ack_number),
    .in_checksum_ok  (in_checksum_ok),
    .window_size     (window_size_r),
    .can_load        (can_load),
    .load            (load),
    .bundle          (bundle),
    .wr_en           (wr_en),
    .wr_slot         (wr_slot),
    .wr_data         (wr_data),
    .rd_slot         (rd_slot),
    .rd_data         (rd_data)
  );

  sws_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Unpack the current result onto the output ports.
  assign out_action         = out_res.action;
  assign out_seq_number     = out_res.seq;
  assign out_packet_payload = out_res.payload;
  assign out_window_full    = out_res.full;
  assign out_packets_held   = out_res.held;
  assign out_last           = out_res.last;

endmodule
